// ===== rtl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 package
// Types, round constants and sequencer states shared by the SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} sha1_msg_t;

	typedef struct packed {
		logic [31:0] digest_word0;
		logic [31:0] digest_word1;
		logic [31:0] digest_word2;
		logic [31:0] digest_word3;
		logic [31:0] digest_word4;
	} sha1_digest_t;

	typedef logic [4:0][31:0] sha1_words_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} sha1_state_t;

	localparam logic [31:0] IV_H0 = 32'h67452301;
	localparam logic [31:0] IV_H1 = 32'hEFCDAB89;
	localparam logic [31:0] IV_H2 = 32'h98BADCFE;
	localparam logic [31:0] IV_H3 = 32'h10325476;
	localparam logic [31:0] IV_H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K_CH     = 32'h5A827999;
	localparam logic [31:0] K_PAR1   = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ    = 32'h8F1BBCDC;
	localparam logic [31:0] K_PAR2   = 32'hCA62C1D6;

	localparam logic [7:0]  PAD_MARK_BYTE = 8'h80;
	localparam logic [5:0]  POS_LAST      = 6'd63;
	localparam logic [5:0]  POS_LENGTH    = 6'd56;
	localparam logic [6:0]  ROUND_LAST    = 7'd79;
	localparam logic [6:0]  ROUND_PAR1    = 7'd20;
	localparam logic [6:0]  ROUND_MAJ     = 7'd40;
	localparam logic [6:0]  ROUND_PAR2    = 7'd60;

endpackage

// ===== rtl/sha1_beat_if.sv =====
// ----------------------------------------------------------------------------
// SHA-1 beat channel
// Valid/ready channel carrying one payload per beat, with source and sink views.
// ----------------------------------------------------------------------------
interface sha1_beat_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// ===== rtl/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Streams a message one byte per beat and returns its 160-bit SHA-1 digest.
// ----------------------------------------------------------------------------
// The msg channel carries data_byte, has_byte and last. A beat with has_byte
// set adds one byte to the message; a beat with last set ends the message,
// with or without a byte. The dig channel returns one beat with the five
// digest words for each message.
// A byte beat adds its byte to the block. The beat that completes a 64-byte
// block starts compression: one round per cycle on the single round unit for
// 80 rounds, then a step that adds the block into the chaining words. After a
// last beat the block feeds padding and length bytes through the same byte
// path and compresses one or two more blocks before the digest is loaded into
// the output register. msg.ready is low while a block is compressed, while
// padding runs and while the digest waits for the output register.
// The digest waits in its output register while the receiver stalls, and the
// block keeps accepting the next message; it holds a later digest back until
// the register is free. Reset sets the initial chaining words and an empty
// message; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module sha1_message_digest
	import sha1_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sha1_beat_if.sink   msg,
	sha1_beat_if.source dig
);

	sha1_state_t state_q, state_d;
	sha1_state_t ret_q, ret_d;

	sha1_words_t chain_q;
	sha1_words_t work_q;
	logic [15:0][31:0] sched_q;
	logic [23:0] partial_q;
	logic [63:0] bit_len_q;
	logic [5:0]  pos_q;
	logic [6:0]  round_q;
	sha1_digest_t digest_q;
	logic dig_valid_q;

	logic       feed_en;
	logic [7:0] feed_byte;
	logic       block_full;
	logic       msg_take;
	logic       out_free;
	logic       out_load;

	logic [31:0] f_val, k_val, t_val, w_new, w_xor;

	assign msg_take = msg.valid && msg.ready;
	assign out_free = !dig_valid_q || dig.ready;
	assign block_full = feed_en && (pos_q == POS_LAST);

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		feed_en   = 1'b0;
		feed_byte = msg.payload.data_byte;
		msg.ready = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg.ready = 1'b1;
				if (msg.valid) begin
					feed_en = msg.payload.has_byte;
					if (msg.payload.has_byte && pos_q == POS_LAST) begin
						state_d = ST_ROUND;
						ret_d   = msg.payload.last ? ST_PAD_MARK : ST_IDLE;
					end else if (msg.payload.last) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				feed_en   = 1'b1;
				feed_byte = PAD_MARK_BYTE;
				if (pos_q == POS_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				feed_byte = 8'h00;
				if (pos_q == POS_LENGTH) begin
					state_d = ST_PAD_LEN;
				end else begin
					feed_en = 1'b1;
					if (pos_q == POS_LAST) begin
						state_d = ST_ROUND;
						ret_d   = ST_PAD_ZERO;
					end
				end
			end
			ST_PAD_LEN: begin
				feed_en   = 1'b1;
				feed_byte = bit_len_q[63:56];
				if (pos_q == POS_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_OUT;
				end
			end
			ST_ROUND: begin
				if (round_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = ret_q;
			end
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (round_q < ROUND_PAR1) begin
			f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
			k_val = K_CH;
		end else if (round_q < ROUND_MAJ) begin
			f_val = work_q[1] ^ work_q[2] ^ work_q[3];
			k_val = K_PAR1;
		end else if (round_q < ROUND_PAR2) begin
			f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) |
				(work_q[2] & work_q[3]);
			k_val = K_MAJ;
		end else begin
			f_val = work_q[1] ^ work_q[2] ^ work_q[3];
			k_val = K_PAR2;
		end
		t_val = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4] + k_val + sched_q[0];
		w_xor = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
		w_new = {w_xor[30:0], w_xor[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q       <= ST_IDLE;
			chain_q     <= {IV_H4, IV_H3, IV_H2, IV_H1, IV_H0};
			work_q      <= '0;
			bit_len_q   <= '0;
			pos_q       <= '0;
			round_q     <= '0;
			dig_valid_q <= 1'b0;
		end else begin
			ret_q <= ret_d;
			if (feed_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (msg_take && msg.payload.has_byte) begin
				bit_len_q <= bit_len_q + 64'd8;
			end else if (state_q == ST_PAD_LEN) begin
				bit_len_q <= {bit_len_q[55:0], 8'h00};
			end
			if (block_full) begin
				work_q <= chain_q;
			end else if (state_q == ST_ROUND) begin
				work_q <= {work_q[3], work_q[2], {work_q[1][1:0], work_q[1][31:2]},
					work_q[0], t_val};
			end
			if (state_q == ST_ROUND) begin
				round_q <= (round_q == ROUND_LAST) ? 7'd0 : round_q + 7'd1;
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end else if (out_load) begin
				chain_q <= {IV_H4, IV_H3, IV_H2, IV_H1, IV_H0};
			end
			if (out_load) begin
				dig_valid_q <= 1'b1;
			end else if (dig.ready) begin
				dig_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feed_en) begin
			partial_q <= {partial_q[15:0], feed_byte};
			if (pos_q[1:0] == 2'd3) begin
				sched_q <= {partial_q, feed_byte, sched_q[15:1]};
			end
		end else if (state_q == ST_ROUND) begin
			sched_q <= {w_new, sched_q[15:1]};
		end
		if (out_load) begin
			digest_q <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
		end
	end

	assign dig.valid   = dig_valid_q;
	assign dig.payload = digest_q;

`ifndef ASSERT_OFF
	a_round_only_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		(round_q != 7'd0) |-> (state_q == ST_ROUND))
		else $error("round counter runs outside compression");

	a_round_end_adds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == ROUND_LAST) |=> (state_q == ST_ADD))
		else $error("compression did not end in the chaining add");

	a_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (pos_q == 6'd0))
		else $error("compression with a partly filled block");

	a_length_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD_LEN) |-> (pos_q >= POS_LENGTH))
		else $error("length bytes outside the length slot");

	a_digest_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dig_valid_q) |-> $past(state_q == ST_OUT))
		else $error("digest beat raised outside the output step");
`endif

endmodule
